// File: hdl/csq_pkg.sv
// Shared types and constants of the counting semaphore with waiter queue.
package csq_pkg;

  // Fixed field widths
  localparam int unsigned CountW  = 17;
  localparam int unsigned DataW   = 16;
  localparam int unsigned InitW   = 15;
  localparam int unsigned IdPortW = 8;
  localparam int unsigned IdWideW = 16;
  localparam int unsigned KindW   = 3;
  localparam int unsigned OpW     = 2;

  // Count limits and reset value of the initial count
  localparam int CountMax  = 32767;
  localparam int InitReset = 1;

  // Operation codes on the request channel
  typedef enum logic [OpW-1:0] {
    OP_WAIT   = 2'd0,
    OP_SIGNAL = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_e;

  // Result kinds on the response channel
  typedef enum logic [KindW-1:0] {
    KIND_PASSED     = 3'd0,
    KIND_BLOCKED    = 3'd1,
    KIND_RELEASED   = 3'd2,
    KIND_SIG_DONE   = 3'd3,
    KIND_FULL       = 3'd4,
    KIND_FLUSH_DONE = 3'd5
  } kind_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RELEASE,
    ST_FINISH
  } ctrl_state_e;

  // Datapath commands issued by the controller
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WAIT,
    CMD_DONE,
    CMD_LOAD,
    CMD_RELEASE,
    CMD_FINISH
  } cmd_e;

  // Datapath status seen by the controller
  typedef struct packed {
    logic out_free;
    logic plan_empty;
    logic rel_last;
  } dp_status_t;

endpackage

// File: hdl/csq_ctrl.sv
// Controller state machine of the counting semaphore.
module csq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  csq_pkg::dp_status_t   status_i,
  output csq_pkg::cmd_e         cmd_o
);
  import csq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;
  logic        is_release_op;

  assign accept        = in_valid_i && in_ready_o;
  assign is_release_op = (opcode_i == OP_SIGNAL) || (opcode_i == OP_FLUSH);

  // Advance the state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_release_op && !status_i.plan_empty) begin
          state_d = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        if (status_i.out_free && status_i.rel_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Drive handshake and datapath commands
  always_comb begin
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          unique case (opcode_i)
            OP_WAIT:   cmd_o = CMD_WAIT;
            OP_SIGNAL,
            OP_FLUSH:  cmd_o = status_i.plan_empty ? CMD_DONE : CMD_LOAD;
            default:   cmd_o = CMD_NONE;
          endcase
        end
      end
      ST_RELEASE: begin
        if (status_i.out_free) begin
          cmd_o = CMD_RELEASE;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o = CMD_FINISH;
        end
      end
      default: cmd_o = CMD_NONE;
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/csq_dp.sv
// Datapath of the counting semaphore: count, waiter queue and result register.
module csq_dp #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  csq_pkg::cmd_e                         cmd_i,
  output csq_pkg::dp_status_t                   status_o,
  input  logic                                  cfg_we_i,
  input  logic [csq_pkg::InitW-1:0]             cfg_wdata_i,
  input  logic [1:0]                            opcode_i,
  input  logic [csq_pkg::IdPortW-1:0]           thread_id_i,
  input  logic [csq_pkg::DataW-1:0]             wait_limit_i,
  input  logic signed [csq_pkg::DataW-1:0]      release_count_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [csq_pkg::KindW-1:0]             kind_o,
  output logic [csq_pkg::IdPortW-1:0]           thread_id_out_o,
  output logic signed [csq_pkg::DataW-1:0]      return_value_o,
  output logic                                  last_o
);
  import csq_pkg::*;

  localparam int unsigned PtrW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned WaitW = $clog2(QUEUE_DEPTH + 1);
  localparam logic signed [CountW-1:0] FullLevel = CountW'(-QUEUE_DEPTH);
  localparam logic signed [CountW-1:0] CountOne  = CountW'(1);
  localparam logic signed [CountW:0]   SatMax    = (CountW + 1)'(CountMax);

  // Wrap a queue pointer
  function automatic logic [PtrW-1:0] adv(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  logic signed [CountW-1:0] count_q, count_d;
  logic [PtrW-1:0]          head_q, head_d, tail_q, tail_d;
  logic [ID_BITS-1:0]       mem_q [QUEUE_DEPTH];
  logic [ID_BITS-1:0]       rd_q;
  logic [WaitW-1:0]         waiters, plan_t, rel_cnt_q, rel_cnt_d;
  logic [DataW-1:0]         plan_rem, rem_q, rem_d, rem_sel, n_u, w_wide;
  logic signed [DataW-1:0]  plan_rv, rv_q, rv_d, wait_rv;
  kind_e                    plan_kind, done_kind_q, done_kind_d;
  logic signed [CountW:0]   sum_w;
  logic signed [CountW-1:0] sat_count;
  logic [IdWideW-1:0]       id_wide, e_id_wide;
  logic [ID_BITS-1:0]       id_in, e_id;
  logic                     wr_en, emit, e_last, out_free, count_pos;
  kind_e                    e_kind;
  logic signed [DataW-1:0]  e_rv;
  logic                     out_valid_q;
  kind_e                    kind_q;
  logic [IdPortW-1:0]       id_out_q;
  logic signed [DataW-1:0]  rv_out_q;
  logic                     last_q;

  // Mask the caller ID to the stored width
  assign id_wide = IdWideW'(thread_id_i);
  assign id_in   = id_wide[ID_BITS-1:0];

  // Occupancy follows from a negative count
  assign waiters   = count_q[CountW-1] ? WaitW'(-count_q) : '0;
  assign w_wide    = DataW'(waiters);
  assign n_u       = release_count_i;
  assign count_pos = !count_q[CountW-1] && (count_q != '0);
  assign wait_rv   = (wait_limit_i == '0) ? DataW'(1) : '0;
  assign out_free  = !out_valid_q || out_ready_i;

  // Plan a signal or flush: threads to release, leftover and return value
  always_comb begin
    plan_t    = '0;
    plan_rem  = '0;
    plan_rv   = '0;
    plan_kind = KIND_SIG_DONE;
    if (opcode_i == OP_FLUSH) begin
      plan_t    = waiters;
      plan_rv   = w_wide;
      plan_kind = KIND_FLUSH_DONE;
    end else if (release_count_i[DataW-1]) begin
      plan_rv = release_count_i;
    end else if (release_count_i == '0) begin
      if (waiters != '0) begin
        plan_t = WaitW'(1);
      end else begin
        plan_rem = DataW'(1);
      end
    end else begin
      if (n_u < w_wide) begin
        plan_t = WaitW'(n_u);
      end else begin
        plan_t   = waiters;
        plan_rem = n_u - w_wide;
      end
      plan_rv = DataW'(plan_t);
    end
  end

  // Add the leftover to the count, saturating at the top
  assign rem_sel   = (cmd_i == CMD_FINISH) ? rem_q : plan_rem;
  assign sum_w     = {count_q[CountW-1], count_q} + $signed({2'b00, rem_sel});
  assign sat_count = (sum_w > SatMax) ? SatMax[CountW-1:0] : sum_w[CountW-1:0];

  // Execute the datapath command
  always_comb begin
    count_d     = count_q;
    head_d      = head_q;
    tail_d      = tail_q;
    rel_cnt_d   = rel_cnt_q;
    rem_d       = rem_q;
    rv_d        = rv_q;
    done_kind_d = done_kind_q;
    wr_en       = 1'b0;
    emit        = 1'b0;
    e_kind      = KIND_PASSED;
    e_id        = '0;
    e_rv        = '0;
    e_last      = 1'b0;
    unique case (cmd_i)
      CMD_NONE: begin
      end
      CMD_WAIT: begin
        emit   = 1'b1;
        e_id   = id_in;
        e_rv   = wait_rv;
        e_last = 1'b1;
        if (count_q <= FullLevel) begin
          e_kind = KIND_FULL;
        end else begin
          count_d = count_q - CountOne;
          if (count_pos) begin
            e_kind = KIND_PASSED;
          end else begin
            e_kind = KIND_BLOCKED;
            wr_en  = 1'b1;
            tail_d = adv(tail_q);
          end
        end
      end
      CMD_DONE: begin
        count_d = sat_count;
        emit    = 1'b1;
        e_kind  = plan_kind;
        e_rv    = plan_rv;
        e_last  = 1'b1;
      end
      CMD_LOAD: begin
        rel_cnt_d   = plan_t;
        rem_d       = plan_rem;
        rv_d        = plan_rv;
        done_kind_d = plan_kind;
      end
      CMD_RELEASE: begin
        emit      = 1'b1;
        e_kind    = KIND_RELEASED;
        e_id      = rd_q;
        head_d    = adv(head_q);
        count_d   = count_q + CountOne;
        rel_cnt_d = rel_cnt_q - WaitW'(1);
      end
      CMD_FINISH: begin
        count_d = sat_count;
        emit    = 1'b1;
        e_kind  = done_kind_q;
        e_rv    = rv_q;
        e_last  = 1'b1;
      end
      default: begin
      end
    endcase
    // Re-initialise the semaphore on a configuration write
    if (cfg_we_i) begin
      count_d = CountW'(cfg_wdata_i);
      head_d  = '0;
      tail_d  = '0;
    end
  end

  // Hold count and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= CountW'(InitReset);
      head_q    <= '0;
      tail_q    <= '0;
      rel_cnt_q <= '0;
    end else begin
      count_q   <= count_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      rel_cnt_q <= rel_cnt_d;
    end
  end

  // Hold the finishing result of a release run
  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    rv_q        <= rv_d;
    done_kind_q <= done_kind_d;
  end

  // Waiter queue: write at tail, prefetch the next head entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail_q] <= id_in;
    end
    if (wr_en && (tail_q == head_d)) begin
      rd_q <= id_in;
    end else begin
      rd_q <= mem_q[head_d];
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  assign e_id_wide = IdWideW'(e_id);
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q   <= e_kind;
      id_out_q <= e_id_wide[IdPortW-1:0];
      rv_out_q <= e_rv;
      last_q   <= e_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign thread_id_out_o = id_out_q;
  assign return_value_o  = rv_out_q;
  assign last_o          = last_q;

  assign status_o.out_free   = out_free;
  assign status_o.plan_empty = (plan_t == '0);
  assign status_o.rel_last   = (rel_cnt_q == WaitW'(1));

endmodule

// File: hdl/counting_semaphore_waiter_queue.sv
// Top level of the counting semaphore with a FIFO of blocked thread IDs.
//
//  channel   direction  handshake                 payload
//  request   in         in_valid_i / in_ready_o   opcode, thread_id, wait_limit, release_count
//  result    out        out_valid_o / out_ready_i kind, thread_id_out, return_value, last
//  config    in         cfg_we_i                  cfg_wdata_i (initial count)
//
// A wait, a negative signal or a signal that releases nobody gives one result. A signal
// or flush that releases t threads is planned, then gives one result per released thread
// and then the closing result; the single read port of the waiter queue sets one release
// a cycle while the result register is free. Reset loads the count with 1 and empties the
// queue. A stalled result register stalls the controller.
module counting_semaphore_waiter_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [csq_pkg::InitW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        opcode_i,
  input  logic [7:0]                        thread_id_i,
  input  logic [15:0]                       wait_limit_i,
  input  logic signed [15:0]                release_count_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        kind_o,
  output logic [7:0]                        thread_id_out_o,
  output logic signed [15:0]                return_value_o,
  output logic                              last_o
);
  import csq_pkg::*;

  cmd_e       cmd;
  dp_status_t status;

  // Sequence the operations
  csq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold count, queue and result register
  csq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (opcode_i),
    .thread_id_i     (thread_id_i),
    .wait_limit_i    (wait_limit_i),
    .release_count_i (release_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .thread_id_out_o (thread_id_out_o),
    .return_value_o  (return_value_o),
    .last_o          (last_o)
  );

`ifndef SYNTH
  // A result is only issued into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_RELEASE || cmd == CMD_FINISH || cmd == CMD_WAIT || cmd == CMD_DONE)
      |-> status.out_free)
    else $error("result issued into a busy output register");

  // A released thread is never the closing result of a transaction
  a_release_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_RELEASED) |-> !last_o)
    else $error("released thread marked as last");

  // Closing results of signal and flush carry no thread
  a_done_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_SIG_DONE || kind_o == KIND_FLUSH_DONE))
      |-> (thread_id_out_o == '0) && last_o)
    else $error("closing result carries a thread ID");

  // The last release of a run is followed by the closing result
  a_release_then_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_RELEASE && status.rel_last) |=> !in_ready_o)
    else $error("request taken before the closing result");
`endif

endmodule
